FILE: rtl/wmmt_pkg.sv
// ----------------------------------------------------------------------------
// wmmt_pkg
// Shared types and fixed constants of the windowed min/max/mean tracker.
// ----------------------------------------------------------------------------
package wmmt_pkg;

  localparam int GAIN_BITS   = 24;
  localparam int OUT_BITS    = 16;
  localparam int SCALE_SHIFT = 18;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd1015762;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef struct packed {
    logic [OUT_BITS-1:0] sample_total;
    logic [OUT_BITS-1:0] scaled_low;
    logic [OUT_BITS-1:0] scaled_mean;
    logic [OUT_BITS-1:0] scaled_high;
    logic                window_empty;
  } result_t;

endpackage

FILE: rtl/wmmt_if.sv
// ----------------------------------------------------------------------------
// wmmt channel interfaces
// Valid/ready channels for sample requests, window reports and gain writes.
// ----------------------------------------------------------------------------
interface wmmt_item_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface wmmt_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_total;
  logic [15:0] scaled_low;
  logic [15:0] scaled_mean;
  logic [15:0] scaled_high;
  logic        window_empty;

  modport source (output valid, output sample_total, output scaled_low,
                  output scaled_mean, output scaled_high, output window_empty,
                  input ready);
  modport sink   (input valid, input sample_total, input scaled_low,
                  input scaled_mean, input scaled_high, input window_empty,
                  output ready);
endinterface

interface wmmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/wmmt_front.sv
// ----------------------------------------------------------------------------
// wmmt_front
// Folds samples into the open window and snapshots it on a close request.
// ----------------------------------------------------------------------------
module wmmt_front #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int SNAP_BITS   = COUNT_BITS + 2 * SAMPLE_BITS + COUNT_BITS + SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   operation,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   q_full,
  output logic                   push,
  output logic [SNAP_BITS-1:0]   push_data
);
  import wmmt_pkg::*;

  localparam int SUM_BITS = COUNT_BITS + SAMPLE_BITS;

  logic [COUNT_BITS-1:0]  count;
  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] low;
  logic [SAMPLE_BITS-1:0] high;
  logic                   take;

  assign item_ready = !q_full;
  assign take       = item_valid && item_ready;
  assign push       = take && (operation == OP_CLOSE);
  assign push_data  = {count, sum, low, high};

  always_ff @(posedge clk) begin
    if (rst || push) begin
      count <= '0;
      sum   <= '0;
      low   <= '1;
      high  <= '0;
    end else if (take) begin
      // hold count and sum once the count saturates
      if (count != '1) begin
        count <= count + 1'b1;
        sum   <= sum + SUM_BITS'(sample);
      end
      if (sample < low) begin
        low <= sample;
      end
      if (sample > high) begin
        high <= sample;
      end
    end
  end

endmodule

FILE: rtl/wmmt_queue.sv
// ----------------------------------------------------------------------------
// wmmt_queue
// Two-entry snapshot queue between the accumulator and the report engine.
// ----------------------------------------------------------------------------
module wmmt_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/wmmt_back.sv
// ----------------------------------------------------------------------------
// wmmt_back
// Divides sum by count, scales low/mean/high by the gain, holds the report.
// ----------------------------------------------------------------------------
module wmmt_back #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int SNAP_BITS   = COUNT_BITS + 2 * SAMPLE_BITS + COUNT_BITS + SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [wmmt_pkg::GAIN_BITS-1:0] gain,
  input  logic                           q_empty,
  input  logic [SNAP_BITS-1:0]           q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wmmt_pkg::result_t              out_data
);
  import wmmt_pkg::*;

  localparam int SUM_BITS  = COUNT_BITS + SAMPLE_BITS;
  localparam int ITER_BITS = $clog2(SAMPLE_BITS);
  localparam int PROD_MIN  = SCALE_SHIFT + OUT_BITS;
  localparam int PROD_BITS = (SAMPLE_BITS + GAIN_BITS > PROD_MIN) ?
                             SAMPLE_BITS + GAIN_BITS : PROD_MIN;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MLOW  = 3'd2;
  localparam logic [2:0] ST_MMEAN = 3'd3;
  localparam logic [2:0] ST_MHIGH = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]             state;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  rem;
  logic [COUNT_BITS-1:0]  rem_next;
  logic [SAMPLE_BITS-1:0] quo;
  logic [SAMPLE_BITS-1:0] low;
  logic [SAMPLE_BITS-1:0] high;
  logic [ITER_BITS-1:0]   iter;
  result_t                work;

  logic [COUNT_BITS-1:0]  snap_count;
  logic [SUM_BITS-1:0]    snap_sum;
  logic [SAMPLE_BITS-1:0] snap_low;
  logic [SAMPLE_BITS-1:0] snap_high;

  logic [COUNT_BITS:0]    trial;
  logic                   qbit;
  logic [SAMPLE_BITS-1:0] mul_op;
  logic [PROD_BITS-1:0]   prod;
  logic [OUT_BITS-1:0]    scaled;
  logic                   load_out;

  assign {snap_count, snap_sum, snap_low, snap_high} = q_data;
  assign pop = (state == ST_IDLE) && !q_empty;

  // one restoring division step: bring down the next dividend bit
  assign trial    = {rem, quo[SAMPLE_BITS-1]};
  assign qbit     = (trial >= {1'b0, cnt});
  assign rem_next = qbit ? COUNT_BITS'(trial - {1'b0, cnt}) : trial[COUNT_BITS-1:0];

  always_comb begin
    unique case (state)
      ST_MLOW:  mul_op = low;
      ST_MMEAN: mul_op = quo;
      ST_MHIGH: mul_op = high;
      default:  mul_op = '0;
    endcase
  end

  assign prod     = PROD_BITS'(mul_op) * PROD_BITS'(gain);
  assign scaled   = prod[SCALE_SHIFT +: OUT_BITS];
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cnt  <= snap_count;
            low  <= snap_low;
            high <= snap_high;
            rem  <= snap_sum[SUM_BITS-1:SAMPLE_BITS];
            quo  <= snap_sum[SAMPLE_BITS-1:0];
            iter <= ITER_BITS'(SAMPLE_BITS - 1);
            work <= '{sample_total: OUT_BITS'(snap_count), scaled_low: '0,
                      scaled_mean: '0, scaled_high: '0,
                      window_empty: (snap_count == '0)};
            if (snap_count == '0) begin
              // empty window: report zeros, skip the divide
              state <= ST_DONE;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= {quo[SAMPLE_BITS-2:0], qbit};
          if (iter == '0) begin
            state <= ST_MLOW;
          end else begin
            iter <= iter - 1'b1;
          end
        end
        ST_MLOW: begin
          work.scaled_low <= scaled;
          state           <= ST_MMEAN;
        end
        ST_MMEAN: begin
          work.scaled_mean <= scaled;
          state            <= ST_MHIGH;
        end
        ST_MHIGH: begin
          work.scaled_high <= scaled;
          state            <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            out_data <= work;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/windowed_min_max_mean_tracker_unit.sv
// Windowed min/max/mean tracker. Add requests fold one sample per cycle into
// the open window (count, sum, lowest, highest); a close request snapshots
// the window into a two-entry queue in the same cycle and clears it, so adds
// keep flowing. The report engine behind the queue loads a snapshot, runs
// the bit-serial mean division, scales low, mean and high in turn on the
// shared gain multiplier and loads the output register; an empty window
// skips the divide and multiply. Only then does it take the next snapshot.
// Requests stall only while two closed windows wait in the queue.
// ----------------------------------------------------------------------------
// windowed_min_max_mean_tracker_unit
// Top level: gain register, accumulator, snapshot queue and report engine.
// ----------------------------------------------------------------------------
module windowed_min_max_mean_tracker_unit #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input logic          clk,
  input logic          rst,
  wmmt_cfg_if.sink     cfg,
  wmmt_item_if.sink    items,
  wmmt_result_if.source results
);
  import wmmt_pkg::*;

  localparam int SNAP_BITS = COUNT_BITS + 2 * SAMPLE_BITS + COUNT_BITS + SAMPLE_BITS;

  logic [GAIN_BITS-1:0] gain;
  logic                 q_full;
  logic                 q_empty;
  logic                 push;
  logic                 pop;
  logic [SNAP_BITS-1:0] push_data;
  logic [SNAP_BITS-1:0] pop_data;
  result_t              res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg.valid) begin
      gain <= cfg.data;
    end
  end

  wmmt_front #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SNAP_BITS   (SNAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .operation  (items.operation),
    .sample     (items.sample),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  wmmt_queue #(
    .WIDTH (SNAP_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  wmmt_back #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SNAP_BITS   (SNAP_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (res)
  );

  assign results.sample_total = res.sample_total;
  assign results.scaled_low   = res.scaled_low;
  assign results.scaled_mean  = res.scaled_mean;
  assign results.scaled_high  = res.scaled_high;
  assign results.window_empty = res.window_empty;

endmodule

FILE: rtl/wmmt_checker.sv
// ----------------------------------------------------------------------------
// wmmt_checker
// Port-level checks on the report channel, bound to the top level.
// ----------------------------------------------------------------------------
module wmmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] sample_total,
  input logic [15:0] scaled_low,
  input logic [15:0] scaled_mean,
  input logic [15:0] scaled_high,
  input logic        window_empty
);

  // a stalled report holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sample_total) &&
      $stable(scaled_low) && $stable(scaled_mean) && $stable(scaled_high) &&
      $stable(window_empty))
    else $error("report changed while stalled");

  // an empty window reports all zero values
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && window_empty |-> sample_total == 16'd0 && scaled_low == 16'd0 &&
      scaled_mean == 16'd0 && scaled_high == 16'd0)
    else $error("empty window report carries nonzero values");

  // nothing is reported right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("report valid right after reset");

endmodule

bind windowed_min_max_mean_tracker_unit wmmt_checker u_wmmt_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .sample_total (results.sample_total),
  .scaled_low   (results.scaled_low),
  .scaled_mean  (results.scaled_mean),
  .scaled_high  (results.scaled_high),
  .window_empty (results.window_empty)
);

FILE: dv/windowed_min_max_mean_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// windowed_min_max_mean_tracker_unit_tb
// Self-checking bench for the windowed tracker: a directed table of requests
// and gain writes, followed by random windows under several gains. Every
// report is checked against the table's expected values or an in-bench
// predictor; the sender idles in bursts and the receiver stalls on its own
// pattern, with long hold-offs that back up the block.
// ----------------------------------------------------------------------------
module windowed_min_max_mean_tracker_unit_tb;
  import wmmt_pkg::*;

  localparam int SMP_BITS      = 12;
  localparam int CNT_BITS      = 16;
  localparam int SUM_BITS      = CNT_BITS + SMP_BITS;
  localparam int PROD_BITS     = GAIN_BITS + SMP_BITS;
  localparam int DRAIN_CYCLES  = 2 * (SMP_BITS + 5) + 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 460;
  localparam int RANDOM_PHASES = 4;
  localparam int SHOW_LIMIT    = 10;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 24'd262144;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 24'hFFFFFF;
  localparam result_t NO_WANT = '0;

  typedef enum logic {ROW_ITEM, ROW_GAIN} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;
  typedef enum logic [1:0] {PAT_ANY, PAT_EDGE, PAT_BAND, PAT_BIT} sample_pat_t;

  typedef struct {
    row_kind_t             kind;
    logic                  op;
    logic [SMP_BITS-1:0]   smp;
    int                    reps;
    logic [GAIN_BITS-1:0]  gain;
    bit                    typed;
    result_t               want;
  } stim_row_t;

  logic clk;
  logic rst;

  wmmt_cfg_if                           cfg_ch();
  wmmt_item_if #(.SAMPLE_BITS(SMP_BITS)) item_ch();
  wmmt_result_if                        report_ch();

  windowed_min_max_mean_tracker_unit #(
    .COUNT_BITS  (CNT_BITS),
    .SAMPLE_BITS (SMP_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (report_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [CNT_BITS-1:0]  win_count;
  logic [SUM_BITS-1:0]  win_sum;
  logic [SMP_BITS-1:0]  win_low;
  logic [SMP_BITS-1:0]  win_high;
  logic [GAIN_BITS-1:0] gain_now;

  result_t   pending_reports[$];
  stim_row_t directed_rows[$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int n_random     = 0;
  bit in_random    = 1'b0;
  int burst_left   = 0;
  bit offering     = 1'b0;

  function automatic void clear_window();
    win_count = '0;
    win_sum   = '0;
    win_low   = '1;
    win_high  = '0;
  endfunction

  function automatic logic [OUT_BITS-1:0] apply_gain(input logic [SMP_BITS-1:0] v);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(v) * PROD_BITS'(gain_now);
    return prod[SCALE_SHIFT +: OUT_BITS];
  endfunction

  // Fold one request into the window; return 1 when it closes with a report.
  function automatic bit fold_request(input logic op, input logic [SMP_BITS-1:0] smp,
                                      output result_t rpt);
    logic [SUM_BITS-1:0] mean;
    rpt = '0;
    if (op == OP_ADD) begin
      // hold count and sum once the count saturates
      if (win_count != '1) begin
        win_count = win_count + 1'b1;
        win_sum   = win_sum + SUM_BITS'(smp);
      end
      if (smp < win_low) win_low = smp;
      if (smp > win_high) win_high = smp;
      return 1'b0;
    end
    if (win_count == '0) begin
      rpt.window_empty = 1'b1;
    end else begin
      mean              = win_sum / SUM_BITS'(win_count);
      rpt.sample_total  = win_count;
      rpt.scaled_low    = apply_gain(win_low);
      rpt.scaled_mean   = apply_gain(mean[SMP_BITS-1:0]);
      rpt.scaled_high   = apply_gain(win_high);
    end
    clear_window();
    return 1'b1;
  endfunction

  function automatic void check_field(input string tag, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("mismatch %s: expected %0d, got %0d", tag, want, got);
    end
  endfunction

  function automatic logic [SMP_BITS-1:0] pick_sample(input sample_pat_t pat,
                                                      input logic [SMP_BITS-1:0] base);
    case (pat)
      PAT_EDGE: return ($urandom_range(0, 1) != 0) ? {SMP_BITS{1'b1}} : {SMP_BITS{1'b0}};
      PAT_BAND: return base ^ SMP_BITS'($urandom_range(0, 15));
      PAT_BIT:  return SMP_BITS'(1) << $urandom_range(0, SMP_BITS - 1);
      default:  return SMP_BITS'($urandom);
    endcase
  endfunction

  task automatic put_row(input row_kind_t kind, input logic op, input logic [SMP_BITS-1:0] smp,
                         input int reps, input logic [GAIN_BITS-1:0] g, input bit typed,
                         input result_t want);
    stim_row_t row;
    row.kind  = kind;
    row.op    = op;
    row.smp   = smp;
    row.reps  = reps;
    row.gain  = g;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one request and wait for it; sender idles in bursts.
  task automatic send_request(input logic op, input logic [SMP_BITS-1:0] smp,
                              input bit typed, input result_t want);
    result_t rpt;
    bit      has_rpt;
    int      gap;
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.sample    <= smp;
    offering = 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    has_rpt = fold_request(op, smp, rpt);
    if (has_rpt) pending_reports.push_back(typed ? want : rpt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic park_sender();
    if (offering) begin
      item_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Write the gain only once every report is out and the engine has drained.
  task automatic write_gain(input logic [GAIN_BITS-1:0] g);
    park_sender();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= g;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    gain_now = g;
  endtask

  // Stimulus
  initial begin
    int                   phase_items;
    int                   win_len;
    int                   roll;
    sample_pat_t          pat;
    logic [SMP_BITS-1:0]  base;
    logic [GAIN_BITS-1:0] g;

    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_ADD;
    item_ch.sample    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    gain_now          = GAIN_RESET;
    clear_window();

    // empty window after reset, then a single zero sample
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b1, {16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
    put_row(ROW_ITEM, OP_ADD,   12'h000, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b1, {16'd1, 16'd0, 16'd0, 16'd0, 1'b0});
    // unity gain: reports read back as raw samples
    put_row(ROW_GAIN, OP_ADD,   12'h000, 1, GAIN_UNITY, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'hFFF, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h000, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b1, {16'd2, 16'd0, 16'd2047, 16'd4095, 1'b0});
    // sample field on a close is dropped
    put_row(ROW_ITEM, OP_ADD,   12'hFFF, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'hABC, 1, '0, 1'b1, {16'd1, 16'd4095, 16'd4095, 16'd4095, 1'b0});
    put_row(ROW_ITEM, OP_CLOSE, 12'hFFF, 2, '0, 1'b1, {16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
    put_row(ROW_ITEM, OP_ADD,   12'h001, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h002, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h004, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b1, {16'd3, 16'd1, 16'd2, 16'd4, 1'b0});
    // zero gain
    put_row(ROW_GAIN, OP_ADD,   12'h000, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'hFFF, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h011, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b1, {16'd2, 16'd0, 16'd0, 16'd0, 1'b0});
    // full-scale gain: outputs wrap to 16 bits
    put_row(ROW_GAIN, OP_ADD,   12'h000, 1, GAIN_MAX, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'hFFF, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h000, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'h800, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_GAIN, OP_ADD,   12'h000, 1, GAIN_RESET, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_ADD,   12'hFFF, 1, '0, 1'b0, NO_WANT);
    put_row(ROW_ITEM, OP_CLOSE, 12'h000, 1, '0, 1'b0, NO_WANT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_GAIN) begin
        write_gain(directed_rows[i].gain);
      end else begin
        repeat (directed_rows[i].reps)
          send_request(directed_rows[i].op, directed_rows[i].smp,
                       directed_rows[i].typed, directed_rows[i].want);
      end
    end

    in_random = 1'b1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       g = GAIN_MAX;
        3:       g = GAIN_RESET;
        default: g = GAIN_BITS'($urandom_range(0, GAIN_MAX));
      endcase
      write_gain(g);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)       win_len = 0;
        else if (roll < 88) win_len = $urandom_range(1, 24);
        else                win_len = $urandom_range(25, 120);
        pat  = sample_pat_t'($urandom_range(0, 3));
        base = SMP_BITS'($urandom);
        repeat (win_len) send_request(OP_ADD, pick_sample(pat, base), 1'b0, NO_WANT);
        send_request(OP_CLOSE, SMP_BITS'($urandom), 1'b0, NO_WANT);
        phase_items += win_len + 1;
      end
    end

    park_sender();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Receiver: own stall pattern, plus long hold-offs during the random part
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_one;
    bit       hold_two;

    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_one  = 1'b0;
    hold_two  = 1'b0;
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else if ((!hold_one && n_random >= 150) || (!hold_two && n_random >= 1100)) begin
        if (hold_one) hold_two = 1'b1;
        hold_one  = 1'b1;
        hold_left = HOLD_CYCLES;
        report_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:    report_ch.ready <= 1'b1;
          RX_COIN:    report_ch.ready <= ($urandom_range(0, 1) != 0);
          RX_QUARTER: report_ch.ready <= ((tick % 4) == 0);
          default:    report_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Report checker and watchdog
  always @(posedge clk) begin
    result_t want;
    bit      item_acc;
    bit      cfg_acc;
    bit      rpt_acc;

    item_acc = !rst && item_ch.valid && item_ch.ready;
    cfg_acc  = !rst && cfg_ch.valid && cfg_ch.ready;
    rpt_acc  = !rst && report_ch.valid && report_ch.ready;

    if (rpt_acc) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected report: total %0d low %0d mean %0d high %0d empty %0d",
                   report_ch.sample_total, report_ch.scaled_low, report_ch.scaled_mean,
                   report_ch.scaled_high, report_ch.window_empty);
      end else begin
        want = pending_reports.pop_front();
        check_field("sample_total", 32'(want.sample_total), 32'(report_ch.sample_total));
        check_field("scaled_low",   32'(want.scaled_low),   32'(report_ch.scaled_low));
        check_field("scaled_mean",  32'(want.scaled_mean),  32'(report_ch.scaled_mean));
        check_field("scaled_high",  32'(want.scaled_high),  32'(report_ch.scaled_high));
        check_field("window_empty", 32'(want.window_empty), 32'(report_ch.window_empty));
      end
    end

    if (item_acc && in_random) n_random <= n_random + 1;

    if (item_acc || cfg_acc || rpt_acc) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
